// ===== hdl/lfe_pkg.sv =====
// Shared types and constants for the LED strip frame encoder.
// Depends on nothing; used by every module of the block.
package lfe_pkg;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_SEND  = 2'd2;

   localparam logic [7:0] LED_MARK = 8'hE0;
   localparam logic [2:0] WORD_BYTES = 3'd4;

   typedef struct packed {
      logic [4:0] bright;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } entry_type;

   localparam entry_type RESET_ENTRY = '{bright: 5'd0, blue: 8'd0, green: 8'd0, red: 8'd0};
   localparam entry_type CLEAR_ENTRY = '{bright: 5'd1, blue: 8'd0, green: 8'd0, red: 8'd0};

   typedef struct packed {
      logic wr_en;
      logic clear;
      logic rd_en;
   } store_ctl_type;

   function automatic logic [31:0] end_word_f(input logic [2:0] nbytes);
      logic [31:0] word;
      word = 32'd0;
      for (int b = 0; b < 4; b++) begin
         if (3'(b) < nbytes) begin
            word[31 - 8 * b -: 8] = 8'hFF;
         end
      end
      return word;
   endfunction

endpackage

// ===== hdl/lfe_store.sv =====
// Colour store of the LED strip frame encoder: a synchronous memory with
// per-entry valid bits and a fill value. Depends on lfe_pkg.
module lfe_store #(
   parameter int LED_COUNT = 36,
   parameter int AW = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lfe_pkg::store_ctl_type ctl,
   input  logic [AW-1:0]          wr_addr,
   input  lfe_pkg::entry_type     wr_entry,
   input  logic [AW-1:0]          rd_addr,
   output lfe_pkg::entry_type     rd_entry
);
   import lfe_pkg::*;

   entry_type            mem [LED_COUNT];
   logic [LED_COUNT-1:0] valid_ff;
   logic [LED_COUNT-1:0] valid_in;
   entry_type            fill_ff;
   entry_type            fill_in;
   entry_type            rd_data_ff;
   logic                 rd_valid_ff;

   // A clear marks every entry as unwritten; unwritten entries read as the fill value.
   always_comb begin
      valid_in = valid_ff;
      fill_in  = fill_ff;
      if (ctl.clear) begin
         valid_in = '0;
         fill_in  = CLEAR_ENTRY;
      end else if (ctl.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         fill_ff  <= RESET_ENTRY;
      end else begin
         valid_ff <= valid_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_entry = rd_valid_ff ? rd_data_ff : fill_ff;

endmodule

// ===== hdl/lfe_send.sv =====
// Frame sequencer of the LED strip frame encoder: walks the store and
// emits the start word, one word per LED and the end word. Depends on lfe_pkg.
module lfe_send #(
   parameter int LED_COUNT = 36,
   parameter int AW = 6,
   parameter int PW = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               send_go,
   output logic               busy,
   output logic               rd_en,
   output logic [AW-1:0]      rd_addr,
   input  lfe_pkg::entry_type rd_entry,
   output logic               rsp_strobe,
   output logic [31:0]        rsp_frame_word,
   output logic [2:0]         rsp_byte_count,
   output logic               rsp_last_word
);
   import lfe_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_START = 2'd1;
   localparam logic [1:0] ST_LEDS  = 2'd2;
   localparam logic [1:0] ST_END   = 2'd3;
   localparam logic [2:0] END_BYTES = 3'(LED_COUNT / 16 + 1);
   localparam logic [31:0] END_WORD = end_word_f(END_BYTES);

   logic [1:0]    state_ff;
   logic [1:0]    state_in;
   logic [PW-1:0] pos_ff;
   logic [PW-1:0] pos_in;

   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff;
      rd_en          = 1'b0;
      rsp_strobe     = 1'b0;
      rsp_frame_word = 32'd0;
      rsp_byte_count = WORD_BYTES;
      rsp_last_word  = 1'b0;
      unique case (state_ff)
         ST_IDLE, ST_END: begin
            if (state_ff == ST_END) begin
               rsp_strobe     = 1'b1;
               rsp_frame_word = END_WORD;
               rsp_byte_count = END_BYTES;
               rsp_last_word  = 1'b1;
            end
            if (send_go) begin
               state_in = ST_START;
               pos_in   = '0;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_START: begin
            rsp_strobe = 1'b1;
            rd_en      = 1'b1;
            pos_in     = pos_ff + PW'(1);
            state_in   = ST_LEDS;
         end
         ST_LEDS: begin
            rsp_strobe     = 1'b1;
            rsp_frame_word = {LED_MARK[7:5], rd_entry};
            if (pos_ff == PW'(LED_COUNT)) begin
               state_in = ST_END;
            end else begin
               rd_en  = 1'b1;
               pos_in = pos_ff + PW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
   end

   assign rd_addr = pos_ff[AW-1:0];
   assign busy    = (state_ff == ST_START) || (state_ff == ST_LEDS);

endmodule

// ===== hdl/led_strip_frame_encoder.sv =====
// Top level of the LED strip frame encoder: command decode, colour store
// and frame sequencer. Depends on lfe_pkg, lfe_store and lfe_send.
//
// Usage: a command is transferred at a rising edge with start high and busy
// low. A write stores one colour entry and a clear resets every entry to off
// with brightness 1; both give no results, so commands of these kinds may
// follow each other in every cycle.
// A send command gives LED_COUNT + 2 result words on consecutive cycles,
// starting the cycle after the transfer: the start word, one word per LED and
// the end word, which carries last_word. busy stays high while the
// sequencer walks through the store at one read per cycle;
// a new command may be transferred in the cycle that shows the end word.
// Each result is on the rsp_ ports for one cycle, marked by rsp_strobe; the
// receiver cannot stall the block and must take every word as it comes.
// Reset is synchronous and sets every entry to zero and the block to idle;
// the store needs no clearing pass.
module led_strip_frame_encoder #(
   parameter int LED_COUNT = 36
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [5:0]  req_led_index,
   input  logic [7:0]  req_red_level,
   input  logic [7:0]  req_green_level,
   input  logic [7:0]  req_blue_level,
   input  logic [7:0]  req_global_level,
   output logic        rsp_strobe,
   output logic [31:0] rsp_frame_word,
   output logic [2:0]  rsp_byte_count,
   output logic        rsp_last_word
);
   import lfe_pkg::*;

   localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int PW = $clog2(LED_COUNT + 1);

   logic          accept;
   logic          send_go;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   entry_type     wr_entry;
   entry_type     rd_entry;
   store_ctl_type ctl;

   assign accept  = start && !busy;
   assign send_go = accept && (req_command == CMD_SEND);

   assign wr_entry = '{bright: req_global_level[4:0], blue: req_blue_level,
                       green: req_green_level, red: req_red_level};

   always_comb begin
      ctl.wr_en = accept && (req_command == CMD_WRITE) && (7'(req_led_index) < 7'(LED_COUNT));
      ctl.clear = accept && (req_command == CMD_CLEAR);
      ctl.rd_en = rd_en;
   end

   lfe_store #(
      .LED_COUNT(LED_COUNT),
      .AW(AW)
   ) u_store (
      .clock(clock),
      .reset(reset),
      .ctl(ctl),
      .wr_addr(req_led_index[AW-1:0]),
      .wr_entry(wr_entry),
      .rd_addr(rd_addr),
      .rd_entry(rd_entry)
   );

   lfe_send #(
      .LED_COUNT(LED_COUNT),
      .AW(AW),
      .PW(PW)
   ) u_send (
      .clock(clock),
      .reset(reset),
      .send_go(send_go),
      .busy(busy),
      .rd_en(rd_en),
      .rd_addr(rd_addr),
      .rd_entry(rd_entry),
      .rsp_strobe(rsp_strobe),
      .rsp_frame_word(rsp_frame_word),
      .rsp_byte_count(rsp_byte_count),
      .rsp_last_word(rsp_last_word)
   );

endmodule

// ===== tb/tb_led_strip_frame_encoder.sv =====
// Self-checking testbench for the LED strip frame encoder: a directed table, then random writes,
// clears, sends and unused commands, each checked word by word against an in-bench colour store.
// Depends on lfe_pkg and led_strip_frame_encoder.
`timescale 1ns / 100ps

module tb_led_strip_frame_encoder;
   import lfe_pkg::*;

   localparam int LED_COUNT = 36;
   localparam int END_BYTES = LED_COUNT / 16 + 1;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [31:0] TYPED_END_WORD = 32'hFFFF_FF00;
   localparam logic [2:0] TYPED_END_BYTES = 3'd3;
   localparam int RANDOM_ITEMS = 408;
   localparam int CYCLE_LIMIT = 200000;
   localparam int N_DIRECTED = 22;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [5:0]  index;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  bright;
      logic        typed;
      logic [31:0] led_word;
   } stim_row_type;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  count;
      logic        last;
   } strip_word_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_command = CMD_WRITE;
   logic [5:0]  req_led_index = 6'd0;
   logic [7:0]  req_red_level = 8'd0;
   logic [7:0]  req_green_level = 8'd0;
   logic [7:0]  req_blue_level = 8'd0;
   logic [7:0]  req_global_level = 8'd0;
   logic        rsp_strobe;
   logic [31:0] rsp_frame_word;
   logic [2:0]  rsp_byte_count;
   logic        rsp_last_word;

   entry_type      colour_store [LED_COUNT];
   strip_word_type words_due [$];
   int          idle_pct = 10;
   int          cycle_count = 0;
   int          fail_count = 0;
   int          words_checked = 0;
   int          sends_done = 0;
   int          writes_done = 0;
   int          clears_done = 0;
   int          dropped_items = 0;

   stim_row_type directed_rows [N_DIRECTED] = '{
      '{CMD_SEND,   6'd0,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 32'hE000_0000},
      '{CMD_CLEAR,  6'd0,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 32'h0},
      '{CMD_SEND,   6'd0,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 32'hE100_0000},
      '{CMD_WRITE,  6'd0,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 32'h0},
      '{CMD_WRITE,  6'd35, 8'h00, 8'hAA, 8'h55, 8'h20, 1'b0, 32'h0},
      '{CMD_WRITE,  6'd36, 8'h11, 8'h22, 8'h33, 8'h1F, 1'b0, 32'h0},
      '{CMD_WRITE,  6'd63, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 32'h0},
      '{CMD_UNUSED, 6'd1,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 32'h0},
      '{CMD_WRITE,  6'd1,  8'h12, 8'h34, 8'h56, 8'h1F, 1'b0, 32'h0},
      '{CMD_WRITE,  6'd34, 8'h80, 8'h01, 8'hFE, 8'hE0, 1'b0, 32'h0},
      '{CMD_SEND,   6'd63, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 32'h0},
      '{CMD_WRITE,  6'd2,  8'h01, 8'h02, 8'h04, 8'h08, 1'b0, 32'h0},
      '{CMD_WRITE,  6'd3,  8'h10, 8'h20, 8'h40, 8'h10, 1'b0, 32'h0},
      '{CMD_SEND,   6'd0,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 32'h0},
      '{CMD_SEND,   6'd0,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 32'h0},
      '{CMD_WRITE,  6'd17, 8'h5A, 8'hA5, 8'hC3, 8'h0F, 1'b0, 32'h0},
      '{CMD_CLEAR,  6'd0,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 32'h0},
      '{CMD_WRITE,  6'd0,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 32'h0},
      '{CMD_UNUSED, 6'd0,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 32'h0},
      '{CMD_SEND,   6'd0,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 32'h0},
      '{CMD_CLEAR,  6'd0,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 32'h0},
      '{CMD_SEND,   6'd0,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 32'hE100_0000}
   };

   led_strip_frame_encoder #(
      .LED_COUNT(LED_COUNT)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_led_index   (req_led_index),
      .req_red_level   (req_red_level),
      .req_green_level (req_green_level),
      .req_blue_level  (req_blue_level),
      .req_global_level(req_global_level),
      .rsp_strobe      (rsp_strobe),
      .rsp_frame_word  (rsp_frame_word),
      .rsp_byte_count  (rsp_byte_count),
      .rsp_last_word   (rsp_last_word)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   function automatic logic [31:0] strip_end_word();
      logic [31:0] word;
      word = 32'd0;
      for (int b = 0; b < END_BYTES && b < 4; b++) begin
         word[31 - 8 * b -: 8] = 8'hFF;
      end
      return word;
   endfunction

   // Updates the colour store for one transfer and queues the words a send produces.
   function automatic void record_transfer(input stim_row_type row);
      strip_word_type sw;
      case (row.cmd)
         CMD_WRITE: begin
            if (row.index < LED_COUNT) begin
               colour_store[row.index] = '{bright: row.bright[4:0], blue: row.blue,
                                           green: row.green, red: row.red};
               writes_done++;
            end
         end
         CMD_CLEAR: begin
            for (int i = 0; i < LED_COUNT; i++) begin
               colour_store[i] = CLEAR_ENTRY;
            end
            clears_done++;
         end
         CMD_SEND: begin
            words_due.push_back('{word: 32'd0, count: WORD_BYTES, last: 1'b0});
            for (int i = 0; i < LED_COUNT; i++) begin
               sw.word = row.typed ? row.led_word : ({LED_MARK, 24'h0} | 32'(colour_store[i]));
               sw.count = WORD_BYTES;
               sw.last = 1'b0;
               words_due.push_back(sw);
            end
            if (row.typed) begin
               words_due.push_back('{word: TYPED_END_WORD, count: TYPED_END_BYTES, last: 1'b1});
            end else begin
               words_due.push_back('{word: strip_end_word(), count: 3'(END_BYTES), last: 1'b1});
            end
            sends_done++;
         end
         default: begin
         end
      endcase
   endfunction

   function automatic stim_row_type random_row();
      stim_row_type row;
      int pick;
      pick = $urandom_range(0, 99);
      row.red = 8'($urandom);
      row.green = 8'($urandom);
      row.blue = 8'($urandom);
      row.bright = 8'($urandom);
      row.typed = 1'b0;
      row.led_word = 32'd0;
      row.index = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(LED_COUNT, 63))
                                              : 6'($urandom_range(0, LED_COUNT - 1));
      if (pick < 4) begin
         row.cmd = CMD_CLEAR;
      end else if (pick < 14) begin
         row.cmd = CMD_SEND;
      end else if (pick < 19) begin
         row.cmd = CMD_UNUSED;
         row.index = 6'($urandom);
      end else begin
         row.cmd = CMD_WRITE;
      end
      return row;
   endfunction

   task automatic issue_command(input stim_row_type row);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_command <= row.cmd;
      req_led_index <= row.index;
      req_red_level <= row.red;
      req_green_level <= row.green;
      req_blue_level <= row.blue;
      req_global_level <= row.bright;
      do @(posedge clock); while (busy !== 1'b0);
      record_transfer(row);
   endtask

   task automatic drain_words();
      start <= 1'b0;
      while (words_due.size() > 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      strip_word_type exp_word;
      if (!reset && rsp_strobe === 1'b1) begin
         if (words_due.size() == 0) begin
            $display("%0t: unexpected frame word: expected none, actual %h/%0d/%0b",
                     $time, rsp_frame_word, rsp_byte_count, rsp_last_word);
            fail_count++;
         end else begin
            exp_word = words_due.pop_front();
            words_checked++;
            if (rsp_frame_word !== exp_word.word) begin
               $display("%0t: frame_word mismatch: expected %h, actual %h",
                        $time, exp_word.word, rsp_frame_word);
               fail_count++;
            end
            if (rsp_byte_count !== exp_word.count) begin
               $display("%0t: byte_count mismatch: expected %0d, actual %0d",
                        $time, exp_word.count, rsp_byte_count);
               fail_count++;
            end
            if (rsp_last_word !== exp_word.last) begin
               $display("%0t: last_word mismatch: expected %0b, actual %0b",
                        $time, exp_word.last, rsp_last_word);
               fail_count++;
            end
         end
      end
   end

   initial begin
      stim_row_type row;
      int issued;
      bit paused;
      issued = 0;
      paused = 1'b0;
      for (int i = 0; i < LED_COUNT; i++) begin
         colour_store[i] = RESET_ENTRY;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < N_DIRECTED; r++) begin
         issue_command(directed_rows[r]);
      end
      drain_words();

      while (issued < RANDOM_ITEMS) begin
         idle_pct = (issued >= 150 && issued < 260) ? 0 : 10;
         if (issued == 300 && !paused) begin
            drain_words();
            paused = 1'b1;
         end
         row = random_row();
         issue_command(row);
         if (row.cmd == CMD_UNUSED || (row.cmd == CMD_WRITE && row.index >= LED_COUNT)) begin
            dropped_items++;
         end
         issued++;
      end

      drain_words();
      repeat (LED_COUNT + 4) @(posedge clock);

      $display("Covered %0d writes, %0d clears and %0d sends; %0d ignored transfers.",
               writes_done, clears_done, sends_done, dropped_items);
      $display("Checked %0d frame words, %0d mismatches.", words_checked, fail_count);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
